// ===== rtl/dpp_pkg.sv =====
// Shared types, register codes and reset values for the depth pixel to point block.
package dpp_pkg;

	localparam int DEPTH_W  = 16;
	localparam int GRAY_W   = 8;
	localparam int INV_W    = 24;
	localparam int CENTER_W = 16;
	localparam int ROT_W    = 16;
	localparam int TRANS_W  = 20;
	localparam int OUT_W    = 19;
	localparam int REG_IDX_W = 3;
	localparam int WR_DATA_W = 60;

	localparam int OUT_MAX = 262143;
	localparam int OUT_MIN = -262144;

	// register indexes on the write port
	localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_COL   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_ROW   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_ZERO = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_ONE  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_TWO  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TRANSLATION  = 3'd7;

	localparam logic [INV_W-1:0]    INV_FOCAL_RST  = 24'd31957;
	localparam logic [CENTER_W-1:0] CENTER_COL_RST = 16'd5112;
	localparam logic [CENTER_W-1:0] CENTER_ROW_RST = 16'd3832;
	localparam logic [3*ROT_W-1:0]  ROT_ROW0_RST   = 48'h4000_0000_0000;
	localparam logic [3*ROT_W-1:0]  ROT_ROW1_RST   = 48'h0000_4000_0000;
	localparam logic [3*ROT_W-1:0]  ROT_ROW2_RST   = 48'h0000_0000_4000;
	localparam logic [3*TRANS_W-1:0] TRANS_RST     = '0;

	// rot[i] is row i; element k of a row sits at rot[i][2-k]
	// trans[2] is x, trans[1] is y, trans[0] is z
	typedef struct packed {
		logic [INV_W-1:0]              inv_focal_x;
		logic [INV_W-1:0]              inv_focal_y;
		logic [CENTER_W-1:0]           center_col;
		logic [CENTER_W-1:0]           center_row;
		logic [2:0][2:0][ROT_W-1:0]    rot;
		logic [2:0][TRANS_W-1:0]       trans;
	} cfg_t;

	// width of a camera-frame coordinate (Q.4 mm, signed) for a given index width
	function automatic int cam_width(input int index_bits);
		int dw;
		dw = ((index_bits + 4) > CENTER_W) ? (index_bits + 4) : CENTER_W;
		return dw + 1 + 18;
	endfunction

endpackage

// ===== rtl/dpp_cfg_regs.sv =====
// Configuration register file: intrinsics, rotation rows and translation.
module dpp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [dpp_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [dpp_pkg::WR_DATA_W-1:0]  wr_data,
	output dpp_pkg::cfg_t                  cfg
);

	dpp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_focal_x <= dpp_pkg::INV_FOCAL_RST;
			cfg_q.inv_focal_y <= dpp_pkg::INV_FOCAL_RST;
			cfg_q.center_col  <= dpp_pkg::CENTER_COL_RST;
			cfg_q.center_row  <= dpp_pkg::CENTER_ROW_RST;
			cfg_q.rot[0]      <= dpp_pkg::ROT_ROW0_RST;
			cfg_q.rot[1]      <= dpp_pkg::ROT_ROW1_RST;
			cfg_q.rot[2]      <= dpp_pkg::ROT_ROW2_RST;
			cfg_q.trans       <= dpp_pkg::TRANS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				dpp_pkg::REG_INV_FOCAL_X:  cfg_q.inv_focal_x <= wr_data[dpp_pkg::INV_W-1:0];
				dpp_pkg::REG_INV_FOCAL_Y:  cfg_q.inv_focal_y <= wr_data[dpp_pkg::INV_W-1:0];
				dpp_pkg::REG_CENTER_COL:   cfg_q.center_col  <= wr_data[dpp_pkg::CENTER_W-1:0];
				dpp_pkg::REG_CENTER_ROW:   cfg_q.center_row  <= wr_data[dpp_pkg::CENTER_W-1:0];
				dpp_pkg::REG_ROT_ROW_ZERO: cfg_q.rot[0] <= wr_data[3*dpp_pkg::ROT_W-1:0];
				dpp_pkg::REG_ROT_ROW_ONE:  cfg_q.rot[1] <= wr_data[3*dpp_pkg::ROT_W-1:0];
				dpp_pkg::REG_ROT_ROW_TWO:  cfg_q.rot[2] <= wr_data[3*dpp_pkg::ROT_W-1:0];
				dpp_pkg::REG_TRANSLATION:  cfg_q.trans  <= wr_data[3*dpp_pkg::TRANS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/dpp_backproject.sv =====
// Stages 1-4: pixel offset, depth product, inverse focal product and rounding to Q.4 mm.
module dpp_backproject #(
	parameter int INDEX_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dpp_pkg::cfg_t                        cfg,
	input  logic                                 in_valid,
	input  logic [INDEX_BITS-1:0]                pix_row,
	input  logic [INDEX_BITS-1:0]                pix_col,
	input  logic [dpp_pkg::DEPTH_W-1:0]          depth_mm,
	input  logic [dpp_pkg::GRAY_W-1:0]           gray,
	output logic                                 cam_valid,
	output logic signed [dpp_pkg::cam_width(INDEX_BITS)-1:0] cam_x,
	output logic signed [dpp_pkg::cam_width(INDEX_BITS)-1:0] cam_y,
	output logic signed [dpp_pkg::cam_width(INDEX_BITS)-1:0] cam_z,
	output logic [dpp_pkg::GRAY_W-1:0]           cam_gray
);

	localparam int CW = dpp_pkg::cam_width(INDEX_BITS);
	localparam int DW = CW - 18;              // pixel offset, Q.4 signed
	localparam int PW = DW + 17;              // offset times depth
	localparam int HALF = dpp_pkg::INV_W / 2; // inverse focal split
	localparam int QW = PW + HALF + 1;        // partial products
	localparam int FW = QW + HALF + 1;        // recombined sum
	localparam logic signed [FW-1:0] RND = FW'(1) << 23;

	// stage 1
	logic                          v_s1;
	logic signed [DW-1:0]          dx_s1, dy_s1;
	logic [dpp_pkg::DEPTH_W-1:0]   d_s1;
	logic [dpp_pkg::GRAY_W-1:0]    gray_s1;
	// stage 2
	logic                          v_s2;
	logic signed [PW-1:0]          px_s2, py_s2;
	logic [dpp_pkg::DEPTH_W-1:0]   d_s2;
	logic [dpp_pkg::GRAY_W-1:0]    gray_s2;
	// stage 3
	logic                          v_s3;
	logic signed [QW-1:0]          pxl_s3, pxh_s3, pyl_s3, pyh_s3;
	logic [dpp_pkg::DEPTH_W-1:0]   d_s3;
	logic [dpp_pkg::GRAY_W-1:0]    gray_s3;
	// stage 4
	logic                          v_s4;
	logic signed [CW-1:0]          cx_s4, cy_s4, cz_s4;
	logic [dpp_pkg::GRAY_W-1:0]    gray_s4;

	logic signed [FW-1:0] fx, fy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid && (depth_mm != '0);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		fx = (FW'(pxh_s3) <<< HALF) + FW'(pxl_s3) + RND;
		fy = (FW'(pyh_s3) <<< HALF) + FW'(pyl_s3) + RND;
	end

	always_ff @(posedge clk) begin
		dx_s1   <= DW'({pix_col, 4'b0000}) - DW'(cfg.center_col);
		dy_s1   <= DW'({pix_row, 4'b0000}) - DW'(cfg.center_row);
		d_s1    <= depth_mm;
		gray_s1 <= gray;

		px_s2   <= dx_s1 * $signed({1'b0, d_s1});
		py_s2   <= dy_s1 * $signed({1'b0, d_s1});
		d_s2    <= d_s1;
		gray_s2 <= gray_s1;

		pxl_s3  <= px_s2 * $signed({1'b0, cfg.inv_focal_x[HALF-1:0]});
		pxh_s3  <= px_s2 * $signed({1'b0, cfg.inv_focal_x[dpp_pkg::INV_W-1:HALF]});
		pyl_s3  <= py_s2 * $signed({1'b0, cfg.inv_focal_y[HALF-1:0]});
		pyh_s3  <= py_s2 * $signed({1'b0, cfg.inv_focal_y[dpp_pkg::INV_W-1:HALF]});
		d_s3    <= d_s2;
		gray_s3 <= gray_s2;

		// round half up: arithmetic shift is a floor
		cx_s4   <= fx[24 +: CW];
		cy_s4   <= fy[24 +: CW];
		cz_s4   <= CW'({d_s3, 4'b0000});
		gray_s4 <= gray_s3;
	end

	assign cam_valid = v_s4;
	assign cam_x     = cx_s4;
	assign cam_y     = cy_s4;
	assign cam_z     = cz_s4;
	assign cam_gray  = gray_s4;

endmodule

// ===== rtl/dpp_transform.sv =====
// Stages 5-8: rotation products, term sums with translation, rounding and saturation.
module dpp_transform #(
	parameter int CAM_W = 35
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dpp_pkg::cfg_t                      cfg,
	input  logic                               cam_valid,
	input  logic signed [CAM_W-1:0]            cam_x,
	input  logic signed [CAM_W-1:0]            cam_y,
	input  logic signed [CAM_W-1:0]            cam_z,
	input  logic [dpp_pkg::GRAY_W-1:0]         cam_gray,
	output logic                               done,
	output logic signed [dpp_pkg::OUT_W-1:0]   pt_x,
	output logic signed [dpp_pkg::OUT_W-1:0]   pt_y,
	output logic signed [dpp_pkg::OUT_W-1:0]   pt_z,
	output logic [dpp_pkg::GRAY_W-1:0]         pt_gray
);

	localparam int RW = dpp_pkg::ROT_W;
	localparam int LO_W = CAM_W / 2;
	localparam int HI_W = CAM_W - LO_W;
	localparam int ML = RW + LO_W + 1;
	localparam int MH = RW + HI_W;
	localparam int TW = RW + CAM_W + 1;
	localparam int AW = TW + 3;
	localparam int SW = AW - 18;
	localparam logic signed [AW-1:0] RND    = AW'(1) << 17;
	localparam logic signed [SW-1:0] SAT_HI = SW'(dpp_pkg::OUT_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(dpp_pkg::OUT_MIN);

	logic                   v_s5, v_s6, v_s7, v_s8;
	logic signed [ML-1:0]   ml_s5 [3][3];
	logic signed [MH-1:0]   mh_s5 [3][3];
	logic signed [TW-1:0]   term_s6 [3][3];
	logic signed [SW-1:0]   sh_s7 [3];
	logic signed [dpp_pkg::OUT_W-1:0] pt_s8 [3];
	logic [dpp_pkg::GRAY_W-1:0] gray_s5, gray_s6, gray_s7, gray_s8;

	logic signed [CAM_W-1:0] cam [3];
	logic signed [RW-1:0]    rot_e [3][3];
	logic signed [AW-1:0]    acc [3];

	always_comb begin
		cam[0] = cam_x;
		cam[1] = cam_y;
		cam[2] = cam_z;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				rot_e[i][k] = $signed(cfg.rot[i][2-k]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc[i] = AW'(term_s6[i][0]) + AW'(term_s6[i][1]) + AW'(term_s6[i][2])
				+ (AW'($signed(cfg.trans[2-i])) <<< 18) + RND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s5 <= cam_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				// coordinate split into unsigned low and signed high halves
				ml_s5[i][k]   <= rot_e[i][k] * $signed({1'b0, cam[k][LO_W-1:0]});
				mh_s5[i][k]   <= rot_e[i][k] * $signed(cam[k][CAM_W-1:LO_W]);
				term_s6[i][k] <= (TW'(mh_s5[i][k]) <<< LO_W) + TW'(ml_s5[i][k]);
			end
			sh_s7[i] <= acc[i][AW-1:18];
			if (sh_s7[i] > SAT_HI)
				pt_s8[i] <= SAT_HI[dpp_pkg::OUT_W-1:0];
			else if (sh_s7[i] < SAT_LO)
				pt_s8[i] <= SAT_LO[dpp_pkg::OUT_W-1:0];
			else
				pt_s8[i] <= sh_s7[i][dpp_pkg::OUT_W-1:0];
		end
		gray_s5 <= cam_gray;
		gray_s6 <= gray_s5;
		gray_s7 <= gray_s6;
		gray_s8 <= gray_s7;
	end

	assign done    = v_s8;
	assign pt_x    = pt_s8[0];
	assign pt_y    = pt_s8[1];
	assign pt_z    = pt_s8[2];
	assign pt_gray = gray_s8;

endmodule

// ===== rtl/depth_pixel_to_point.sv =====
// Top level: depth pixel back-projection and rigid transform pipeline.
//
// One pixel is taken on every clock at which start is high; busy is always low, since the
// pipeline never stalls. A pixel with non-zero depth produces one point on pt_x, pt_y, pt_z
// and pt_gray with done high for one cycle, once it has passed every stage; a zero-depth
// pixel produces nothing. Its path: pixel offset, two chained multiplier stages of the
// back-projection (offset times depth, then times inverse focal), rounding, rotation,
// recombining, translation sum, rounding, saturation. The receiver cannot stall results.
// Register writes take effect on the next cycle and should be made with the pipeline empty.
module depth_pixel_to_point #(
	parameter int INDEX_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [INDEX_BITS-1:0]             pix_row,
	input  logic [INDEX_BITS-1:0]             pix_col,
	input  logic [dpp_pkg::DEPTH_W-1:0]       depth_mm,
	input  logic [dpp_pkg::GRAY_W-1:0]        gray,
	input  logic                              wr_en,
	input  logic [dpp_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [dpp_pkg::WR_DATA_W-1:0]     wr_data,
	output logic                              done,
	output logic signed [dpp_pkg::OUT_W-1:0]  pt_x,
	output logic signed [dpp_pkg::OUT_W-1:0]  pt_y,
	output logic signed [dpp_pkg::OUT_W-1:0]  pt_z,
	output logic [dpp_pkg::GRAY_W-1:0]        pt_gray
);

	localparam int CW = dpp_pkg::cam_width(INDEX_BITS);

	dpp_pkg::cfg_t          cfg;
	logic                   take;
	logic                   cam_valid;
	logic signed [CW-1:0]   cam_x, cam_y, cam_z;
	logic [dpp_pkg::GRAY_W-1:0] cam_gray;

	assign busy = 1'b0;
	assign take = start && !busy;

	dpp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	dpp_backproject #(
		.INDEX_BITS (INDEX_BITS)
	) u_bp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (take),
		.pix_row   (pix_row),
		.pix_col   (pix_col),
		.depth_mm  (depth_mm),
		.gray      (gray),
		.cam_valid (cam_valid),
		.cam_x     (cam_x),
		.cam_y     (cam_y),
		.cam_z     (cam_z),
		.cam_gray  (cam_gray)
	);

	dpp_transform #(
		.CAM_W (CW)
	) u_xf (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cam_valid (cam_valid),
		.cam_x     (cam_x),
		.cam_y     (cam_y),
		.cam_z     (cam_z),
		.cam_gray  (cam_gray),
		.done      (done),
		.pt_x      (pt_x),
		.pt_y      (pt_y),
		.pt_z      (pt_z),
		.pt_gray   (pt_gray)
	);

endmodule

// ===== rtl/dpp_checker.sv =====
// Port-level checker for the depth pixel to point pipeline, bound to the top level.
module dpp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [dpp_pkg::DEPTH_W-1:0]       depth_mm,
	input logic [dpp_pkg::GRAY_W-1:0]        gray,
	input logic                              done,
	input logic [dpp_pkg::GRAY_W-1:0]        pt_gray
);

	// the pipeline never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// every accepted pixel with depth yields a point
	a_point_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && depth_mm != '0) |-> ##8 done)
		else $error("point missing for accepted pixel");

	// no point without a matching accepted pixel with depth
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && depth_mm != '0, 8))
		else $error("point without source pixel");

	// intensity travels with its pixel
	a_gray_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pt_gray == $past(gray, 8)))
		else $error("intensity mismatch");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (.*);
